### hdl/smcd_pkg.sv
package smcd_pkg;

    // default widths of the wrapping counters
    localparam int MINUTE_WIDTH_DEF     = 32;
    localparam int STEP_COUNT_WIDTH_DEF = 32;

    // configuration port geometry
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 18;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MS_PER_MINUTE    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_STEP_DELAY = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_STEP_DELAY   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MINUTE_STEPS     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_APPROACH_STEPS   = 3'd4;

    // register reset values
    localparam logic [17:0] MS_PER_MINUTE_RST    = 18'd60000;
    localparam logic [7:0]  START_STEP_DELAY_RST = 8'd20;
    localparam logic [7:0]  MIN_STEP_DELAY_RST   = 8'd2;
    localparam logic [15:0] MINUTE_STEPS_RST     = 16'd938;
    localparam logic [7:0]  APPROACH_STEPS_RST   = 8'd20;

    typedef struct packed {
        logic [17:0] ms_per_minute;
        logic [7:0]  start_step_delay;
        logic [7:0]  min_step_delay;
        logic [15:0] minute_steps;
        logic [7:0]  approach_steps;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       moving;
    } drive_status_t;

    // half-step coil pattern, bit i is coil column i
    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pattern;
        case (phase)
            3'd0:    pattern = 4'h6;
            3'd1:    pattern = 4'h4;
            3'd2:    pattern = 4'hC;
            3'd3:    pattern = 4'h8;
            3'd4:    pattern = 4'h9;
            3'd5:    pattern = 4'h1;
            3'd6:    pattern = 4'h3;
            3'd7:    pattern = 4'h2;
            default: pattern = 4'h0;
        endcase
        return pattern;
    endfunction

endpackage

### hdl/smcd_if.sv
// millisecond tick channel
interface smcd_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// coil drive result channel
interface smcd_drive_if #(
    parameter int MINUTE_WIDTH = smcd_pkg::MINUTE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [3:0]              coils;
    logic                    moving;
    logic [MINUTE_WIDTH-1:0] minute_count;

    modport source (output valid, output coils, output moving, output minute_count,
                    input ready);
    modport sink (input valid, input coils, input moving, input minute_count,
                  output ready);
endinterface

### hdl/stepper_minute_clock_drive_unit.sv
// channel   dir  beat payload                      handshake
// ticks     in   tick                              valid / ready
// drive     out  coils, moving, minute_count       valid / ready
// wr_*      in   wr_index, wr_data                 wr_en, no wait
//
// one tick beat per cycle while drive beats are taken, each beat gives one drive beat in the next cycle
// the counters and step timing settle in one pass between the state registers
// and the drive output register, the coil step count uses one multiplier
// after reset the startup sequence runs on the first tick beats
// ticks stay ready while the output register is empty or being taken
module stepper_minute_clock_drive_unit #(
    parameter int MINUTE_WIDTH     = smcd_pkg::MINUTE_WIDTH_DEF,
    parameter int STEP_COUNT_WIDTH = smcd_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    smcd_tick_if.sink                            ticks,
    smcd_drive_if.source                         drive,
    input  logic                                 wr_en,
    input  logic [smcd_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [smcd_pkg::CFG_DATA_WIDTH-1:0]  wr_data
);

    smcd_pkg::cfg_t          cfg_reg;
    logic                    accept;
    logic                    advance;
    logic [MINUTE_WIDTH-1:0] minutes_next;
    smcd_pkg::drive_status_t status;

    logic                    out_valid_reg;
    logic [3:0]              coils_reg;
    logic                    moving_reg;
    logic [MINUTE_WIDTH-1:0] minute_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ms_per_minute    <= smcd_pkg::MS_PER_MINUTE_RST;
            cfg_reg.start_step_delay <= smcd_pkg::START_STEP_DELAY_RST;
            cfg_reg.min_step_delay   <= smcd_pkg::MIN_STEP_DELAY_RST;
            cfg_reg.minute_steps     <= smcd_pkg::MINUTE_STEPS_RST;
            cfg_reg.approach_steps   <= smcd_pkg::APPROACH_STEPS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                smcd_pkg::CFG_MS_PER_MINUTE:    cfg_reg.ms_per_minute    <= wr_data;
                smcd_pkg::CFG_START_STEP_DELAY: cfg_reg.start_step_delay <= wr_data[7:0];
                smcd_pkg::CFG_MIN_STEP_DELAY:   cfg_reg.min_step_delay   <= wr_data[7:0];
                smcd_pkg::CFG_MINUTE_STEPS:     cfg_reg.minute_steps     <= wr_data[15:0];
                smcd_pkg::CFG_APPROACH_STEPS:   cfg_reg.approach_steps   <= wr_data[7:0];
                default:                        ;
            endcase
        end
    end

    // input handshake
    assign ticks.ready = !out_valid_reg || drive.ready;
    assign accept      = ticks.valid && ticks.ready;
    assign advance     = accept && ticks.tick;

    smcd_minute_counter #(
        .MINUTE_WIDTH (MINUTE_WIDTH)
    ) u_minute_counter (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .ms_per_minute (cfg_reg.ms_per_minute),
        .minutes_next  (minutes_next)
    );

    smcd_sequencer #(
        .MINUTE_WIDTH     (MINUTE_WIDTH),
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    ) u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg_reg),
        .minutes_next (minutes_next),
        .status       (status)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coils_reg  <= status.coils;
            moving_reg <= status.moving;
            minute_reg <= minutes_next;
        end
    end

    assign drive.valid        = out_valid_reg;
    assign drive.coils        = coils_reg;
    assign drive.moving       = moving_reg;
    assign drive.minute_count = minute_reg;

endmodule

### hdl/smcd_minute_counter.sv
module smcd_minute_counter #(
    parameter int MINUTE_WIDTH = smcd_pkg::MINUTE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [17:0]             ms_per_minute,
    output logic [MINUTE_WIDTH-1:0] minutes_next
);

    logic [17:0]             ms_reg;
    logic [17:0]             ms_next;
    logic [MINUTE_WIDTH-1:0] minutes_reg;
    logic [17:0]             ms_inc;

    // millisecond count, wraps into a minute at the limit
    always_comb
    begin
        ms_inc       = ms_reg + 18'd1;
        ms_next      = ms_reg;
        minutes_next = minutes_reg;
        if (advance)
        begin
            if (ms_inc >= ms_per_minute || ms_inc == 18'd0)
            begin
                ms_next      = 18'd0;
                minutes_next = minutes_reg + {{(MINUTE_WIDTH-1){1'b0}}, 1'b1};
            end
            else
            begin
                ms_next = ms_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg      <= 18'd0;
            minutes_reg <= '0;
        end
        else
        begin
            ms_reg      <= ms_next;
            minutes_reg <= minutes_next;
        end
    end

endmodule

### hdl/smcd_sequencer.sv
module smcd_sequencer #(
    parameter int MINUTE_WIDTH     = smcd_pkg::MINUTE_WIDTH_DEF,
    parameter int STEP_COUNT_WIDTH = smcd_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  smcd_pkg::cfg_t          cfg,
    input  logic [MINUTE_WIDTH-1:0] minutes_next,
    output smcd_pkg::drive_status_t status
);

    localparam int PROD_WIDTH = 16 + MINUTE_WIDTH;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_START_BACK = 7'b0000010,
        ST_START_FWD  = 7'b0000100,
        ST_START_MAIN = 7'b0001000,
        ST_BACK       = 7'b0010000,
        ST_FWD        = 7'b0100000,
        ST_MAIN       = 7'b1000000
    } stage_t;

    stage_t                      stage_reg, stage_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [STEP_COUNT_WIDTH-1:0] steps_left_reg, steps_left_next;
    logic                        dir_back_reg, dir_back_next;
    logic [7:0]                  step_hold_reg, step_hold_next;
    logic [7:0]                  hold_left_reg, hold_left_next;
    logic [3:0]                  coil_reg, coil_next;
    logic [MINUTE_WIDTH-1:0]     last_reg, last_next;

    logic [7:0]                  hold_dec;
    logic                        due;
    logic                        need_new;
    logic                        go_idle_chk;
    logic                        go_main;
    stage_t                      r_stage;
    logic [STEP_COUNT_WIDTH-1:0] r_count;
    logic                        r_dir;
    logic                        r_load;
    logic [MINUTE_WIDTH-1:0]     r_last;
    logic [MINUTE_WIDTH-1:0]     delta;
    logic [PROD_WIDTH-1:0]       product;
    logic [STEP_COUNT_WIDTH-1:0] main_count;
    logic [STEP_COUNT_WIDTH-1:0] approach_count;
    logic [STEP_COUNT_WIDTH-1:0] spm_count;
    stage_t                      cur_stage;
    logic [STEP_COUNT_WIDTH-1:0] cur_count;
    logic                        cur_dir;
    logic [7:0]                  cur_hold;
    logic                        do_step;

    // step count of the main move of a served minute change
    assign delta          = minutes_next - last_reg;
    assign product        = {{MINUTE_WIDTH{1'b0}}, cfg.minute_steps}
                          * {16'd0, delta};
    assign main_count     = STEP_COUNT_WIDTH'(product);
    assign approach_count = STEP_COUNT_WIDTH'(cfg.approach_steps);
    assign spm_count      = STEP_COUNT_WIDTH'(cfg.minute_steps);

    // hold countdown while a move runs
    assign hold_dec = (stage_reg != ST_IDLE && hold_left_reg != 8'd0)
                    ? hold_left_reg - 8'd1 : hold_left_reg;
    assign due      = (hold_dec == 8'd0);
    assign need_new = due && (stage_reg == ST_IDLE || steps_left_reg == '0);

    // walk past finished and empty moves to the next one that has a step
    always_comb
    begin
        go_idle_chk = 1'b0;
        go_main     = 1'b0;
        r_stage     = stage_reg;
        r_count     = steps_left_reg;
        r_dir       = dir_back_reg;
        r_load      = 1'b0;
        r_last      = last_reg;
        case (stage_reg)
            ST_START_BACK:
            begin
                if (cfg.approach_steps != 8'd0)
                begin
                    r_stage = ST_START_FWD;
                    r_count = approach_count;
                    r_dir   = 1'b0;
                    r_load  = 1'b1;
                end
                else if (cfg.minute_steps != 16'd0)
                begin
                    r_stage = ST_START_MAIN;
                    r_count = spm_count;
                    r_dir   = 1'b0;
                    r_load  = 1'b1;
                end
                else
                begin
                    go_idle_chk = 1'b1;
                end
            end
            ST_START_FWD:
            begin
                if (cfg.minute_steps != 16'd0)
                begin
                    r_stage = ST_START_MAIN;
                    r_count = spm_count;
                    r_dir   = 1'b0;
                    r_load  = 1'b1;
                end
                else
                begin
                    go_idle_chk = 1'b1;
                end
            end
            ST_BACK:
            begin
                if (cfg.approach_steps != 8'd0)
                begin
                    r_stage = ST_FWD;
                    r_count = approach_count;
                    r_dir   = 1'b0;
                    r_load  = 1'b1;
                end
                else
                begin
                    go_main = 1'b1;
                end
            end
            ST_FWD:
            begin
                go_main = 1'b1;
            end
            default:
            begin
                go_idle_chk = 1'b1;
            end
        endcase

        // idle: start the backlash approach when the minute has moved on, or the main move if the approach is empty
        if (go_idle_chk)
        begin
            if (minutes_next != last_reg)
            begin
                if (cfg.approach_steps != 8'd0)
                begin
                    r_stage = ST_BACK;
                    r_count = approach_count;
                    r_dir   = 1'b1;
                    r_load  = 1'b1;
                end
                else
                begin
                    go_main = 1'b1;
                end
            end
            else
            begin
                r_stage = ST_IDLE;
            end
        end

        // main move covers every minute not yet served
        if (go_main)
        begin
            r_last  = minutes_next;
            r_count = main_count;
            r_dir   = 1'b0;
            r_load  = 1'b1;
            r_stage = (main_count != '0) ? ST_MAIN : ST_IDLE;
        end
    end

    // take a step or let the hold run down
    always_comb
    begin
        if (need_new)
        begin
            cur_stage = r_stage;
            cur_count = r_count;
            cur_dir   = r_dir;
            cur_hold  = r_load ? cfg.start_step_delay : step_hold_reg;
            last_next = r_last;
        end
        else
        begin
            cur_stage = stage_reg;
            cur_count = steps_left_reg;
            cur_dir   = dir_back_reg;
            cur_hold  = step_hold_reg;
            last_next = last_reg;
        end

        do_step        = due && cur_stage != ST_IDLE && cur_count != '0;
        stage_next     = cur_stage;
        dir_back_next  = cur_dir;
        phase_next     = phase_reg;
        coil_next      = need_new ? 4'h0 : coil_reg;
        hold_left_next = hold_dec;
        step_hold_next = cur_hold;
        steps_left_next = cur_count;

        if (do_step)
        begin
            phase_next      = cur_dir ? phase_reg - 3'd1 : phase_reg + 3'd1;
            coil_next       = smcd_pkg::phase_coils(phase_next);
            hold_left_next  = (cur_hold == 8'd0) ? 8'd1 : cur_hold;
            step_hold_next  = (cur_hold > cfg.min_step_delay) ? cur_hold - 8'd1 : cur_hold;
            steps_left_next = cur_count - {{(STEP_COUNT_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= ST_START_BACK;
            phase_reg      <= 3'd0;
            steps_left_reg <= STEP_COUNT_WIDTH'(smcd_pkg::APPROACH_STEPS_RST);
            dir_back_reg   <= 1'b1;
            step_hold_reg  <= smcd_pkg::START_STEP_DELAY_RST;
            hold_left_reg  <= 8'd0;
            coil_reg       <= 4'h0;
            last_reg       <= '0;
        end
        else if (advance)
        begin
            stage_reg      <= stage_next;
            phase_reg      <= phase_next;
            steps_left_reg <= steps_left_next;
            dir_back_reg   <= dir_back_next;
            step_hold_reg  <= step_hold_next;
            hold_left_reg  <= hold_left_next;
            coil_reg       <= coil_next;
            last_reg       <= last_next;
        end
    end

    // drive view after this beat
    always_comb
    begin
        status.coils  = advance ? coil_next : coil_reg;
        status.moving = advance ? (stage_next != ST_IDLE) : (stage_reg != ST_IDLE);
    end

endmodule

### tb/tb_stepper_minute_clock_drive_unit.sv
`timescale 1ns / 100ps

module tb_stepper_minute_clock_drive_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int IDX_W          = smcd_pkg::CFG_INDEX_WIDTH;
    localparam int DATA_W         = smcd_pkg::CFG_DATA_WIDTH;

    // half-step rows, nibble n is the coil pattern of phase n
    localparam logic [31:0] HALF_STEP_ROWS = 32'h2319_8C46;

    // top of the register index space, everything past the last register is unmapped
    localparam logic [IDX_W-1:0] CFG_INDEX_TOP = '1;

    typedef enum logic [2:0] {
        STG_IDLE,
        STG_BOOT_BACK,
        STG_BOOT_FWD,
        STG_BOOT_MAIN,
        STG_BACK,
        STG_FWD,
        STG_MAIN
    } stage_t;

    typedef struct packed {
        logic [3:0]  coils;
        logic        moving;
        logic [31:0] minute_count;
    } drive_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [DATA_W-1:0] wr_data;

    smcd_tick_if  tick_ch ();
    smcd_drive_if drive_ch ();

    stepper_minute_clock_drive_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .ticks    (tick_ch),
        .drive    (drive_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // clock drive state as the block should hold it
    smcd_pkg::cfg_t clock_cfg;
    logic [17:0]    ms_count;
    logic [31:0]    minute_total;
    logic [31:0]    served_minute;
    logic [31:0]    steps_to_go;
    logic [2:0]     phase;
    logic           going_back;
    logic [7:0]     hold_reload;
    logic [7:0]     hold_count;
    stage_t         stage;
    logic [3:0]     coil_bits;

    // stimulus and scoreboard bookkeeping
    logic        tick_backlog[$];
    drive_beat_t drive_forecast[$];
    int          ticks_pending = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          tick_gap = 0;
    int          stall_left = 0;
    int          gap_odds = 0;
    int          stall_odds = 0;

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] value);
        case (idx)
            smcd_pkg::CFG_MS_PER_MINUTE:    clock_cfg.ms_per_minute = value[17:0];
            smcd_pkg::CFG_START_STEP_DELAY: clock_cfg.start_step_delay = value[7:0];
            smcd_pkg::CFG_MIN_STEP_DELAY:   clock_cfg.min_step_delay = value[7:0];
            smcd_pkg::CFG_MINUTE_STEPS:     clock_cfg.minute_steps = value[15:0];
            smcd_pkg::CFG_APPROACH_STEPS:   clock_cfg.approach_steps = value[7:0];
            default: ;
        endcase
    endfunction

    function automatic void start_move(input logic [31:0] count, input logic back);
        steps_to_go = count;
        going_back  = back;
        hold_reload = clock_cfg.start_step_delay;
    endfunction

    function automatic void advance_stage();
        logic [31:0] delta;
        case (stage)
            STG_BOOT_BACK:
            begin
                stage = STG_BOOT_FWD;
                start_move({24'd0, clock_cfg.approach_steps}, 1'b0);
            end
            STG_BOOT_FWD:
            begin
                stage = STG_BOOT_MAIN;
                start_move({16'd0, clock_cfg.minute_steps}, 1'b0);
            end
            STG_BACK:
            begin
                stage = STG_FWD;
                start_move({24'd0, clock_cfg.approach_steps}, 1'b0);
            end
            STG_FWD:
            begin
                delta         = minute_total - served_minute;
                served_minute = minute_total;
                stage         = STG_MAIN;
                start_move({16'd0, clock_cfg.minute_steps} * delta, 1'b0);
            end
            default: stage = STG_IDLE;
        endcase
    endfunction

    // hold countdown, then steps, move ends and stage changes within one tick
    function automatic void step_motor();
        int guard;
        if (stage != STG_IDLE && hold_count != 0)
            hold_count = hold_count - 8'd1;
        for (guard = 0; guard < 16 && hold_count == 0; guard++)
        begin
            if (stage == STG_IDLE)
            begin
                if (minute_total == served_minute)
                    break;
                stage = STG_BACK;
                start_move({24'd0, clock_cfg.approach_steps}, 1'b1);
                continue;
            end
            if (steps_to_go != 0)
            begin
                phase      = going_back ? phase - 3'd1 : phase + 3'd1;
                coil_bits  = HALF_STEP_ROWS[{phase, 2'b00} +: 4];
                hold_count = (hold_reload != 0) ? hold_reload : 8'd1;
                if (hold_reload > clock_cfg.min_step_delay)
                    hold_reload = hold_reload - 8'd1;
                steps_to_go = steps_to_go - 32'd1;
                break;
            end
            coil_bits = 4'd0;
            advance_stage();
        end
    endfunction

    function automatic drive_beat_t predict_drive(input logic tick);
        logic [17:0] next_ms;
        drive_beat_t beat;
        if (tick)
        begin
            next_ms = ms_count + 18'd1;
            if (next_ms >= clock_cfg.ms_per_minute || next_ms == '0)
            begin
                ms_count     = '0;
                minute_total = minute_total + 32'd1;
            end
            else
            begin
                ms_count = next_ms;
            end
            step_motor();
        end
        beat.coils        = coil_bits;
        beat.moving       = (stage != STG_IDLE);
        beat.minute_count = minute_total;
        return beat;
    endfunction

    function automatic void reset_clock_state();
        clock_cfg.ms_per_minute    = smcd_pkg::MS_PER_MINUTE_RST;
        clock_cfg.start_step_delay = smcd_pkg::START_STEP_DELAY_RST;
        clock_cfg.min_step_delay   = smcd_pkg::MIN_STEP_DELAY_RST;
        clock_cfg.minute_steps     = smcd_pkg::MINUTE_STEPS_RST;
        clock_cfg.approach_steps   = smcd_pkg::APPROACH_STEPS_RST;
        ms_count      = '0;
        minute_total  = '0;
        served_minute = '0;
        phase         = '0;
        hold_count    = '0;
        coil_bits     = '0;
        stage         = STG_BOOT_BACK;
        start_move({24'd0, clock_cfg.approach_steps}, 1'b1);
    endfunction

    // one register write per cycle, bits above the register width may get random junk
    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value, input int width);
        logic [DATA_W-1:0] data;
        data = value;
        if ($urandom_range(0, 1) == 1)
            data = data | DATA_W'($urandom() << width);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        apply_register(idx, data);
    endtask

    task automatic write_unmapped();
        write_register(IDX_W'($urandom_range(smcd_pkg::CFG_APPROACH_STEPS + 1, CFG_INDEX_TOP)),
                       DATA_W'($urandom()), DATA_W);
    endtask

    // all beats in, all drive beats out, idle bursts over, then a short settle
    task automatic wait_idle();
        while (ticks_pending != 0 || drive_forecast.size() != 0
               || tick_gap != 0 || stall_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick(input logic tick);
        tick_backlog.push_back(tick);
        ticks_pending = ticks_pending + 1;
    endtask

    // one in zero_odds beats carries no time
    task automatic queue_ticks(input int count, input int zero_odds);
        int n;
        for (n = 0; n < count; n++)
            push_tick($urandom_range(1, zero_odds) != 1);
    endtask

    task automatic retune();
        wait_idle();
        if ($urandom_range(0, 2) != 0)
            case ($urandom_range(0, 5))
                0:       write_register(smcd_pkg::CFG_MS_PER_MINUTE, '0, 18);
                1:       write_register(smcd_pkg::CFG_MS_PER_MINUTE, 18'd1, 18);
                default: write_register(smcd_pkg::CFG_MS_PER_MINUTE,
                                        18'($urandom_range(2, 40)), 18);
            endcase
        if ($urandom_range(0, 1) == 1)
            write_register(smcd_pkg::CFG_START_STEP_DELAY, 18'($urandom_range(0, 5)), 8);
        if ($urandom_range(0, 1) == 1)
            write_register(smcd_pkg::CFG_MIN_STEP_DELAY, 18'($urandom_range(0, 3)), 8);
        if ($urandom_range(0, 1) == 1)
            write_register(smcd_pkg::CFG_MINUTE_STEPS, 18'($urandom_range(0, 4)), 16);
        if ($urandom_range(0, 1) == 1)
            write_register(smcd_pkg::CFG_APPROACH_STEPS, 18'($urandom_range(0, 3)), 8);
        if ($urandom_range(0, 3) == 0)
            write_unmapped();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic int pick_idle_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // tick source, random gaps after a beat
    always @(posedge clk)
    begin
        if (rst_n && (!tick_ch.valid || tick_ch.ready))
        begin
            if (tick_gap != 0)
            begin
                tick_ch.valid <= 1'b0;
                tick_gap = tick_gap - 1;
            end
            else if (tick_backlog.size() != 0)
            begin
                tick_ch.valid <= 1'b1;
                tick_ch.tick  <= tick_backlog.pop_front();
                if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                    tick_gap = $urandom_range(1, 16);
            end
            else
            begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // drive sink, random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                drive_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                drive_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end
            else
            begin
                drive_ch.ready <= 1'b1;
            end
        end
    end

    // predict on each tick beat, check each drive beat, watch for a hang
    always @(posedge clk)
    begin
        drive_beat_t want;
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                drive_forecast.push_back(predict_drive(tick_ch.tick));
                ticks_pending = ticks_pending - 1;
            end
            if (drive_ch.valid && drive_ch.ready)
            begin
                if (drive_forecast.size() == 0)
                begin
                    $error("drive beat with nothing predicted: coils %0h moving %0b minutes %0d",
                           drive_ch.coils, drive_ch.moving, drive_ch.minute_count);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = drive_forecast.pop_front();
                    if (drive_ch.coils !== want.coils)
                    begin
                        $error("coils: expected %0h, actual %0h", want.coils, drive_ch.coils);
                        mismatches = mismatches + 1;
                    end
                    if (drive_ch.moving !== want.moving)
                    begin
                        $error("moving: expected %0b, actual %0b", want.moving, drive_ch.moving);
                        mismatches = mismatches + 1;
                    end
                    if (drive_ch.minute_count !== want.minute_count)
                    begin
                        $error("minute_count: expected %0d, actual %0d",
                               want.minute_count, drive_ch.minute_count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if ((tick_ch.valid && tick_ch.ready) || (drive_ch.valid && drive_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        tick_ch.valid  = 1'b0;
        tick_ch.tick   = 1'b0;
        drive_ch.ready = 1'b1;
        wr_en          = 1'b0;
        wr_index       = '0;
        wr_data        = '0;
        reset_clock_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // startup back move under reset registers, both tick values
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b1);

        // zero cases: minute on every tick, zero hold, zero length approach
        wait_idle();
        write_register(smcd_pkg::CFG_MIN_STEP_DELAY, '0, 8);
        write_register(smcd_pkg::CFG_MS_PER_MINUTE, '0, 18);
        write_register(smcd_pkg::CFG_START_STEP_DELAY, '0, 8);
        write_register(smcd_pkg::CFG_APPROACH_STEPS, '0, 8);
        write_register(smcd_pkg::CFG_MINUTE_STEPS, 18'd1, 16);
        write_unmapped();
        @(posedge clk);
        wr_en <= 1'b0;
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        queue_ticks(8, 4);

        // long run to drain the startup sequence
        wait_idle();
        write_register(smcd_pkg::CFG_MS_PER_MINUTE, 18'd1, 18);
        write_register(smcd_pkg::CFG_MINUTE_STEPS, 18'd2, 16);
        @(posedge clk);
        wr_en <= 1'b0;
        gap_odds   = pick_idle_odds();
        stall_odds = pick_idle_odds();
        queue_ticks(180, 16);

        // random register settings mid move
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            retune();
            gap_odds   = pick_idle_odds();
            stall_odds = pick_idle_odds();
            queue_ticks(40, 4);
        end

        // every register at its top value, no idling
        gap_odds   = 0;
        stall_odds = 0;
        wait_idle();
        write_register(smcd_pkg::CFG_MS_PER_MINUTE, 18'h3FFFF, 18);
        write_register(smcd_pkg::CFG_START_STEP_DELAY, 18'hFF, 8);
        write_register(smcd_pkg::CFG_MIN_STEP_DELAY, 18'hFF, 8);
        write_register(smcd_pkg::CFG_MINUTE_STEPS, 18'hFFFF, 16);
        write_register(smcd_pkg::CFG_APPROACH_STEPS, 18'hFF, 8);
        @(posedge clk);
        wr_en <= 1'b0;
        queue_ticks(40, 4);

        wait_idle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hdl/smcd_pkg.sv
hdl/smcd_if.sv
hdl/smcd_minute_counter.sv
hdl/smcd_sequencer.sv
hdl/stepper_minute_clock_drive_unit.sv
tb/tb_stepper_minute_clock_drive_unit.sv
